>>> hw/rtl/hsv_to_rgb_converter_assert.svh
// Assertion macros for the HSV to RGB converter, clocked on clk and disabled in reset
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// same-cycle implication
`define HSV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HSV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/hsv_pkg.sv
// Shared constants, stage types and sector table of the HSV to RGB converter
`default_nettype none

package hsv_pkg;

    localparam int HUE_W  = 16;
    localparam int FRAC_W = 13;
    localparam int CH_W   = 8;
    localparam int Q60_W  = 7;
    localparam int SEC_W  = 3;
    localparam int F_W    = 11;
    localparam int DIST_W = 10;
    localparam int SV_W   = 25;
    localparam int XNUM_W = 34;
    localparam int ZNUM_W = 25;
    localparam int XQ_W   = 12;

    localparam logic [FRAC_W-1:0] Q_ONE        = 13'd4096;
    localparam logic [F_W-1:0]    SECTOR_UNITS = 11'd960;
    localparam logic [HUE_W-1:0]  PERIOD_UNITS = 16'd1920;
    localparam logic [Q60_W-1:0]  SECTOR_COUNT = 7'd6;
    localparam logic [11:0]       RECIP15      = 12'd2185;
    localparam logic [5:0]        RECIP6       = 6'd43;
    localparam logic [21:0]       X_SCALE      = 22'd3932160;

    typedef enum logic [1:0] {
        COMP_CHROMA,
        COMP_SECOND,
        COMP_ZERO
    } comp_t;

    typedef struct packed {
        comp_t r;
        comp_t g;
        comp_t b;
    } place_t;

    typedef struct packed {
        logic valid;
        logic adv;
    } pipe_ctl_t;

    typedef struct packed {
        logic [SEC_W-1:0]  sector;
        logic [DIST_W-1:0] hue_dist;
        logic [SV_W-1:0]   sv;
        logic [FRAC_W-1:0] v;
    } front_t;

    typedef struct packed {
        logic [SEC_W-1:0] sector;
        logic [XQ_W-1:0]  x_q;
        logic [CH_W-1:0]  z_out;
        logic [CH_W-1:0]  c_out;
    } scale_t;

    function automatic place_t place_sel(input logic [SEC_W-1:0] sector);
        place_t p;
        unique case (sector)
            3'd0:    p = '{COMP_CHROMA, COMP_SECOND, COMP_ZERO};
            3'd1:    p = '{COMP_SECOND, COMP_CHROMA, COMP_ZERO};
            3'd2:    p = '{COMP_ZERO, COMP_CHROMA, COMP_SECOND};
            3'd3:    p = '{COMP_ZERO, COMP_SECOND, COMP_CHROMA};
            3'd4:    p = '{COMP_SECOND, COMP_ZERO, COMP_CHROMA};
            3'd5:    p = '{COMP_CHROMA, COMP_ZERO, COMP_SECOND};
            default: p = '{COMP_ZERO, COMP_ZERO, COMP_ZERO};
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hsv_in_if.sv
// Pixel input channel: hue, saturation and brightness with valid/ready
`default_nettype none

interface hsv_in_if;
    logic                            valid;
    logic                            ready;
    logic [hsv_pkg::HUE_W-1:0]       hue;
    logic [hsv_pkg::FRAC_W-1:0]      saturation;
    logic [hsv_pkg::FRAC_W-1:0]      brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/hsv_out_if.sv
// Pixel output channel: red, green and blue with valid/ready
`default_nettype none

interface hsv_out_if;
    logic                      valid;
    logic                      ready;
    logic [hsv_pkg::CH_W-1:0]  red;
    logic [hsv_pkg::CH_W-1:0]  green;
    logic [hsv_pkg::CH_W-1:0]  blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/hsv_front.sv
// Front stages: clamp fractions, split hue into sector and distance, form s*v
`default_nettype none

module hsv_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire hsv_pkg::pipe_ctl_t           ctl,
    input  wire logic [hsv_pkg::HUE_W-1:0]    hue,
    input  wire logic [hsv_pkg::FRAC_W-1:0]   saturation,
    input  wire logic [hsv_pkg::FRAC_W-1:0]   brightness,
    output logic                              valid,
    output hsv_pkg::front_t                   data
);

    logic                          v1_reg;
    logic [hsv_pkg::HUE_W-1:0]     hue_reg;
    logic [hsv_pkg::FRAC_W-1:0]    s_reg;
    logic [hsv_pkg::FRAC_W-1:0]    v_reg;
    logic [hsv_pkg::Q60_W-1:0]     q60_reg;
    logic                          v2_reg;
    hsv_pkg::front_t               data_reg;

    logic [hsv_pkg::FRAC_W-1:0]    s_c;
    logic [hsv_pkg::FRAC_W-1:0]    v_c;
    logic [21:0]                   q60_prod;
    logic [12:0]                   q6_prod;
    logic [hsv_pkg::Q60_W-1:0]     sec_full;
    logic [hsv_pkg::HUE_W-1:0]     per_base;
    logic [hsv_pkg::HUE_W-1:0]     f_full;
    logic [hsv_pkg::F_W-1:0]       f;
    logic [hsv_pkg::F_W-1:0]       dist_full;
    logic [2*hsv_pkg::FRAC_W-1:0]  sv_full;
    hsv_pkg::front_t               data_next;

    always_comb
    begin
        s_c      = (saturation > hsv_pkg::Q_ONE) ? hsv_pkg::Q_ONE : saturation;
        v_c      = (brightness > hsv_pkg::Q_ONE) ? hsv_pkg::Q_ONE : brightness;
        q60_prod = 22'(hue[15:6]) * 22'(hsv_pkg::RECIP15);
    end

    always_comb
    begin
        q6_prod   = 13'(q60_reg) * 13'(hsv_pkg::RECIP6);
        sec_full  = q60_reg - 7'(q6_prod[12:8]) * hsv_pkg::SECTOR_COUNT;
        per_base  = 16'(q60_reg[6:1]) * hsv_pkg::PERIOD_UNITS;
        f_full    = hue_reg - per_base;
        f         = f_full[hsv_pkg::F_W-1:0];
        dist_full = (f >= hsv_pkg::SECTOR_UNITS) ? (f - hsv_pkg::SECTOR_UNITS)
                                                  : (hsv_pkg::SECTOR_UNITS - f);
        sv_full   = 26'(s_reg) * 26'(v_reg);
        data_next.sector   = sec_full[hsv_pkg::SEC_W-1:0];
        data_next.hue_dist = dist_full[hsv_pkg::DIST_W-1:0];
        data_next.sv       = sv_full[hsv_pkg::SV_W-1:0];
        data_next.v        = v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (ctl.adv)
        begin
            v1_reg <= ctl.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            hue_reg  <= hue;
            s_reg    <= s_c;
            v_reg    <= v_c;
            q60_reg  <= q60_prod[21:15];
            data_reg <= data_next;
        end
    end

    assign valid = v2_reg;
    assign data  = data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/hsv_scale.sv
// Scale stages: secondary and minimum numerators, then scale all three by 255
`default_nettype none

module hsv_scale (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hsv_pkg::pipe_ctl_t ctl,
    input  wire hsv_pkg::front_t    front,
    output logic                    valid,
    output hsv_pkg::scale_t         data
);

    logic                          v3_reg;
    logic [hsv_pkg::SEC_W-1:0]     sec_reg;
    logic [hsv_pkg::XNUM_W-1:0]    xnum_reg;
    logic [hsv_pkg::ZNUM_W-1:0]    znum_reg;
    logic [hsv_pkg::FRAC_W-1:0]    v_reg;
    logic                          v4_reg;
    hsv_pkg::scale_t               data_reg;

    logic [hsv_pkg::XNUM_W-1:0]    vx;
    logic [hsv_pkg::XNUM_W-1:0]    svd;
    logic [hsv_pkg::XNUM_W-1:0]    xnum_next;
    logic [hsv_pkg::ZNUM_W-1:0]    znum_next;
    logic [41:0]                   x255;
    logic [32:0]                   z255;
    logic [20:0]                   c255;
    hsv_pkg::scale_t               data_next;

    always_comb
    begin
        vx        = 34'(front.v) * 34'(hsv_pkg::X_SCALE);
        svd       = 34'(front.sv) * 34'(front.hue_dist);
        xnum_next = vx - svd;
        znum_next = {front.v, 12'b0} - front.sv;
    end

    always_comb
    begin
        x255 = {xnum_reg, 8'b0} - 42'(xnum_reg);
        z255 = {znum_reg, 8'b0} - 33'(znum_reg);
        c255 = {v_reg, 8'b0} - 21'(v_reg);
        data_next.sector = sec_reg;
        data_next.x_q    = x255[41:30];
        data_next.z_out  = z255[31:24];
        data_next.c_out  = c255[19:12];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (ctl.adv)
        begin
            v3_reg <= ctl.valid;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            sec_reg  <= front.sector;
            xnum_reg <= xnum_next;
            znum_reg <= znum_next;
            v_reg    <= front.v;
            data_reg <= data_next;
        end
    end

    assign valid = v4_reg;
    assign data  = data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/hsv_place.sv
// Output stage: finish the secondary component and place components by sector
`default_nettype none

module hsv_place (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hsv_pkg::pipe_ctl_t ctl,
    input  wire hsv_pkg::scale_t    scale,
    output logic                    valid,
    output logic [hsv_pkg::CH_W-1:0] red,
    output logic [hsv_pkg::CH_W-1:0] green,
    output logic [hsv_pkg::CH_W-1:0] blue
);

    logic                       v5_reg;
    logic [hsv_pkg::CH_W-1:0]   red_reg;
    logic [hsv_pkg::CH_W-1:0]   green_reg;
    logic [hsv_pkg::CH_W-1:0]   blue_reg;

    logic [23:0]                x_prod;
    logic [hsv_pkg::CH_W-1:0]   x_out;
    hsv_pkg::place_t            sel;
    logic [hsv_pkg::CH_W-1:0]   red_next;
    logic [hsv_pkg::CH_W-1:0]   green_next;
    logic [hsv_pkg::CH_W-1:0]   blue_next;

    function automatic logic [hsv_pkg::CH_W-1:0] pick(
        input hsv_pkg::comp_t          code,
        input logic [hsv_pkg::CH_W-1:0] c,
        input logic [hsv_pkg::CH_W-1:0] x,
        input logic [hsv_pkg::CH_W-1:0] z
    );
        logic [hsv_pkg::CH_W-1:0] r;
        case (code)
            hsv_pkg::COMP_CHROMA: r = c;
            hsv_pkg::COMP_SECOND: r = x;
            default:              r = z;
        endcase
        return r;
    endfunction

    always_comb
    begin
        x_prod     = 24'(scale.x_q) * 24'(hsv_pkg::RECIP15);
        x_out      = x_prod[22:15];
        sel        = hsv_pkg::place_sel(scale.sector);
        red_next   = pick(sel.r, scale.c_out, x_out, scale.z_out);
        green_next = pick(sel.g, scale.c_out, x_out, scale.z_out);
        blue_next  = pick(sel.b, scale.c_out, x_out, scale.z_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (ctl.adv)
        begin
            v5_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign valid = v5_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

`default_nettype wire

>>> hw/rtl/hsv_to_rgb_converter.sv
// HSV to RGB converter top level: five-stage pipeline from hsv transaction to rgb.
// An accepted hsv transaction reaches rgb through the front, scale and place stages in order.
// Throughput: one transaction per cycle; a stalled rgb output freezes all five stages.
// Reset: rst_n clears every stage valid bit asynchronously; payload is not reset.
`default_nettype none

`include "hsv_to_rgb_converter_assert.svh"

module hsv_to_rgb_converter (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hsv_in_if.sink     hsv,
    hsv_out_if.source  rgb
);

    logic                  adv;
    logic                  front_valid;
    hsv_pkg::front_t       front_data;
    logic                  scale_valid;
    hsv_pkg::scale_t       scale_data;
    hsv_pkg::pipe_ctl_t    ctl_front;
    hsv_pkg::pipe_ctl_t    ctl_scale;
    hsv_pkg::pipe_ctl_t    ctl_place;

    assign adv       = !rgb.valid || rgb.ready;
    assign hsv.ready = adv;

    assign ctl_front = '{valid: hsv.valid, adv: adv};
    assign ctl_scale = '{valid: front_valid, adv: adv};
    assign ctl_place = '{valid: scale_valid, adv: adv};

    hsv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_front),
        .hue        (hsv.hue),
        .saturation (hsv.saturation),
        .brightness (hsv.brightness),
        .valid      (front_valid),
        .data       (front_data)
    );

    hsv_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl_scale),
        .front (front_data),
        .valid (scale_valid),
        .data  (scale_data)
    );

    hsv_place u_place (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl_place),
        .scale (scale_data),
        .valid (rgb.valid),
        .red   (rgb.red),
        .green (rgb.green),
        .blue  (rgb.blue)
    );

    `HSV_ASSERT_SAME(a_front_range, front_valid,
        (front_data.hue_dist <= 10'd960) && (front_data.sector <= 3'd5),
        "front stage sector or distance out of range")

    `HSV_ASSERT_SAME(a_min_le_max, scale_valid, scale_data.z_out <= scale_data.c_out,
        "minimum component exceeds brightness component")

    `HSV_ASSERT_NEXT(a_stall_freeze, rgb.valid && !rgb.ready,
        $stable(scale_valid) && $stable(scale_data),
        "inner stage moved while output stalled")

endmodule

`default_nettype wire
